// ===== design/bpf_pkg.sv =====
// Package for the byte pipe: word types, codes and default sizes.
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

  // Default ring buffer size in bytes (a power of two).
  localparam int BUFFER_BYTES_DEF = 4096;

  // Fixed field widths.
  localparam int DATA_W = 8;
  localparam int LEN_W  = 13;

  typedef enum logic [1:0] {
    KIND_READ        = 2'd0,
    KIND_WRITE       = 2'd1,
    KIND_CLOSE_READ  = 2'd2,
    KIND_CLOSE_WRITE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_WOULD_BLOCK = 2'd1,
    STATUS_EOF         = 2'd2,
    STATUS_BROKEN_PIPE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  data;
    logic [LEN_W-1:0]   message_length;
    logic               first_of_message;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    status_t            status;
    logic [LEN_W-1:0]   fill_level;
    logic               wake_readers;
    logic               wake_writers;
    logic               pipe_released;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/bpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/byte_pipe_fifo.sv =====
// Top level of the byte pipe: ring buffer control, end flags and result register.
// A result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result slot is drained; each word makes at
// most one access to the ring memory, whose one write port and one registered read port set that rate.
// Reset (synchronous, active high): both counters and the message count go to
// zero, both ends open, no result pending; the ring memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module byte_pipe_fifo #(
  parameter int BUFFER_BYTES = bpf_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bpf_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bpf_pkg::out_word_t      out_word
);

  import bpf_pkg::*;

  // The counters carry one bit beyond the buffer address so that a full
  // buffer and an empty one can be told apart.
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W  = ADDR_W + 1;
  // Common width for comparing fill values against the 13-bit length field.
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(BUFFER_BYTES);

  // Pipe state.
  logic [CNT_W-1:0] read_counter;
  logic [CNT_W-1:0] write_counter;
  logic             reader_open;
  logic             writer_open;
  logic [LEN_W-1:0] bytes_left;

  logic [CNT_W-1:0] read_counter_next;
  logic [CNT_W-1:0] write_counter_next;
  logic             reader_open_next;
  logic             writer_open_next;
  logic [LEN_W-1:0] bytes_left_next;

  // Result register. The read byte itself sits in the RAM's output register,
  // which only moves when a word is accepted, so it holds while stalled.
  logic             read_ok;
  status_t          status;
  logic [LEN_W-1:0] fill_level;
  logic             wake_readers;
  logic             wake_writers;
  logic             pipe_released;

  logic             read_ok_next;
  status_t          status_next;
  logic             wake_readers_next;
  logic             wake_writers_next;
  logic             pipe_released_next;

  logic             accept;
  logic             ram_we;
  logic             ram_re;
  logic [DATA_W-1:0] ram_rdata;

  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  space;
  logic [CNT_W-1:0]  fill_after;
  logic [WIDE_W-1:0] fill_after_wide;
  logic [WIDE_W-1:0] space_wide;
  logic [WIDE_W-1:0] length_wide;

  // A new word enters whenever the result slot is empty or is being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign fill        = write_counter - read_counter;
  assign space       = CAPACITY - fill;
  assign space_wide  = WIDE_W'(space);
  assign length_wide = WIDE_W'(in_word.message_length);

  // Decide what this word does to the pipe and what it reports.
  always_comb begin
    read_counter_next  = read_counter;
    write_counter_next = write_counter;
    reader_open_next   = reader_open;
    writer_open_next   = writer_open;
    bytes_left_next    = bytes_left;
    read_ok_next       = 1'b0;
    status_next        = STATUS_OK;
    wake_readers_next  = 1'b0;
    wake_writers_next  = 1'b0;
    pipe_released_next = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;

    case (in_word.kind)
      KIND_READ: begin
        // Reads are served from whatever is buffered, even after the
        // reader end has closed.
        if (fill != '0) begin
          ram_re            = 1'b1;
          read_ok_next      = 1'b1;
          read_counter_next = read_counter + 1'b1;
          wake_writers_next = 1'b1;
        end else begin
          status_next = writer_open ? STATUS_WOULD_BLOCK : STATUS_EOF;
        end
      end
      KIND_WRITE: begin
        if (in_word.first_of_message) begin
          // A new message always drops whatever was left of the last one.
          bytes_left_next = '0;
          if (in_word.message_length == '0) begin
            status_next = STATUS_OK;
          end else if (!reader_open) begin
            status_next = STATUS_BROKEN_PIPE;
          end else if (space_wide >= length_wide) begin
            // The whole message fits, so its space is reserved now.
            ram_we             = 1'b1;
            write_counter_next = write_counter + 1'b1;
            bytes_left_next    = in_word.message_length - 1'b1;
            wake_readers_next  = (in_word.message_length == LEN_W'(1));
          end else begin
            status_next = STATUS_WOULD_BLOCK;
          end
        end else if (bytes_left != '0 && fill != CAPACITY) begin
          // Continuation of an accepted message; the reader closing in the
          // meantime does not stop it.
          ram_we             = 1'b1;
          write_counter_next = write_counter + 1'b1;
          bytes_left_next    = bytes_left - 1'b1;
          wake_readers_next  = (bytes_left == LEN_W'(1));
        end else begin
          status_next = STATUS_WOULD_BLOCK;
        end
      end
      KIND_CLOSE_READ: begin
        if (reader_open) begin
          reader_open_next   = 1'b0;
          wake_writers_next  = writer_open;
          pipe_released_next = !writer_open;
        end
      end
      KIND_CLOSE_WRITE: begin
        bytes_left_next = '0;
        if (writer_open) begin
          writer_open_next   = 1'b0;
          wake_readers_next  = reader_open;
          pipe_released_next = !reader_open;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  assign fill_after      = write_counter_next - read_counter_next;
  assign fill_after_wide = WIDE_W'(fill_after);

  bpf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (write_counter[ADDR_W-1:0]),
    .wdata (in_word.data),
    .re    (accept && ram_re),
    .raddr (read_counter[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_counter  <= '0;
      write_counter <= '0;
      reader_open   <= 1'b1;
      writer_open   <= 1'b1;
      bytes_left    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        read_counter  <= read_counter_next;
        write_counter <= write_counter_next;
        reader_open   <= reader_open_next;
        writer_open   <= writer_open_next;
        bytes_left    <= bytes_left_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only when a word is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_ok       <= read_ok_next;
      status        <= status_next;
      fill_level    <= fill_after_wide[LEN_W-1:0];
      wake_readers  <= wake_readers_next;
      wake_writers  <= wake_writers_next;
      pipe_released <= pipe_released_next;
    end
  end

  always_comb begin
    out_word.read_data     = read_ok ? ram_rdata : '0;
    out_word.status        = status;
    out_word.fill_level    = fill_level;
    out_word.wake_readers  = wake_readers;
    out_word.wake_writers  = wake_writers;
    out_word.pipe_released = pipe_released;
  end

endmodule

`default_nettype wire
